[sv/apt_pkg.sv]
// Shared types, constants and codes of the aging peer table.
package apt_pkg;

	localparam int PER_TYPE_LIMIT = 8;
	localparam int TABLE_DEPTH    = 2 * PER_TYPE_LIMIT;
	localparam int IDX_W          = $clog2(TABLE_DEPTH);
	localparam int TOTAL_W        = $clog2(TABLE_DEPTH + 1);
	localparam int KC_W           = $clog2(PER_TYPE_LIMIT + 1);

	localparam logic [31:0] TIMEOUT_RESET    = 32'd5000;
	localparam logic [15:0] FIXED_PORT_RESET = 16'd39051;

	localparam int PADDR_W = 3;
	localparam logic REG_TIMEOUT    = 1'b0;
	localparam logic REG_FIXED_PORT = 1'b1;

	typedef enum logic [2:0] {
		CMD_ADD     = 3'd0,
		CMD_QUERY   = 3'd1,
		CMD_REFRESH = 3'd2,
		CMD_SWEEP   = 3'd3,
		CMD_CLEAR   = 3'd4
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic        service_type;
		logic [31:0] ip_address;
		logic [15:0] port_number;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic        matched;
		logic        inserted;
		logic        subscribe_request;
		logic [15:0] subscribe_port;
		logic [4:0]  entry_count;
		logic [3:0]  active_count;
		logic [4:0]  removed_count;
		logic        count_changed;
	} rsp_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] address;
		logic [15:0] port;
		logic [31:0] last_seen;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic walk;
		logic update;
		logic emit;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic needs_walk;
		logic walk_end;
		logic hit;
		logic out_free;
	} ctrl_status_t;

endpackage

[sv/apt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module apt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/apt_ctrl.sv]
// Controller state machine of the aging peer table.
module apt_ctrl
	import apt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	input  ctrl_status_t status,
	output ctrl_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = status.needs_walk ? ST_WALK : ST_UPDATE;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.hit || status.walk_end) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[sv/apt_datapath.sv]
// Datapath of the aging peer table: entry RAM, counters, walk and result register.
module apt_datapath
	import apt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  req_t         req,
	input  logic [31:0]  timeout_ms,
	input  logic [15:0]  fixed_port,
	input  ctrl_cmd_t    cmd,
	output ctrl_status_t status,
	input  logic         rsp_ready,
	output logic         rsp_valid,
	output rsp_t         rsp
);

	// Item held for the whole operation.
	logic [2:0]         cmd_q;
	logic               kind_q;
	logic [31:0]        addr_q;
	logic [15:0]        mport_q;
	logic               use_port_q;
	logic [31:0]        now_q;

	// Walk pointers and the read pipeline.
	logic [TOTAL_W-1:0] rd_q;
	logic [TOTAL_W-1:0] wr_q;
	logic               pv_s1;
	logic [IDX_W-1:0]   idx_s1;

	// Table bookkeeping.
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] before_q;
	logic [KC_W-1:0]    kc_q [2];

	// Per-item outcome.
	logic               matched_q;
	logic               inserted_q;
	logic               sub_q;
	logic [TOTAL_W-1:0] removed_q;

	rsp_t               out_q;
	logic               out_valid_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	entry_t             ram_wdata;
	entry_t             rdata;

	logic               is_sweep;
	logic               issue;
	logic               hit_raw;
	logic               drop;
	logic               eval;
	logic               append_ok;
	logic [31:0]        age;
	rsp_t               rsp_d;

	apt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	assign is_sweep = (cmd_q == CMD_SWEEP);
	assign issue    = (rd_q < total_q);
	assign eval     = cmd.walk && pv_s1;
	assign age      = now_q - rdata.last_seen;
	assign drop     = (age > timeout_ms);
	assign hit_raw  = (rdata.kind == kind_q) && (rdata.address == addr_q)
		&& (!use_port_q || (rdata.port == mport_q));
	assign append_ok = (cmd_q == CMD_ADD) && !matched_q
		&& (kc_q[kind_q] < KC_W'(PER_TYPE_LIMIT))
		&& (total_q < TOTAL_W'(TABLE_DEPTH));

	assign status.needs_walk = (req.command == CMD_ADD) || (req.command == CMD_QUERY)
		|| (req.command == CMD_REFRESH) || (req.command == CMD_SWEEP);
	assign status.walk_end   = !pv_s1 && !issue;
	assign status.hit        = eval && !is_sweep && hit_raw;
	assign status.out_free   = !out_valid_q || rsp_ready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = rdata;
		if (eval) begin
			if (is_sweep) begin
				ram_we    = !drop;
				ram_waddr = wr_q[IDX_W-1:0];
			end else if (hit_raw) begin
				ram_we              = 1'b1;
				ram_wdata.last_seen = now_q;
			end
		end else if (cmd.update && append_ok) begin
			ram_we    = 1'b1;
			ram_waddr = total_q[IDX_W-1:0];
			ram_wdata = '{kind: kind_q, address: addr_q, port: mport_q, last_seen: now_q};
		end
	end

	always_comb begin
		rsp_d                   = '0;
		rsp_d.matched           = matched_q;
		rsp_d.inserted          = inserted_q;
		rsp_d.subscribe_request = sub_q;
		rsp_d.subscribe_port    = sub_q ? mport_q : 16'd0;
		rsp_d.entry_count       = 5'(total_q);
		rsp_d.active_count      = (kc_q[0] != '0) ? 4'(kc_q[0]) : 4'(kc_q[1]);
		rsp_d.removed_count     = 5'(removed_q);
		rsp_d.count_changed     = (total_q != before_q);
	end

	// Item, walk index and result capture; payload only.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= req.command;
			kind_q <= req.service_type;
			addr_q <= req.ip_address;
			now_q  <= req.now_ms;
			case (req.command)
				CMD_ADD: begin
					mport_q    <= req.service_type ? req.port_number : fixed_port;
					use_port_q <= 1'b1;
				end
				CMD_REFRESH: begin
					mport_q    <= fixed_port;
					use_port_q <= !req.service_type;
				end
				default: begin
					mport_q    <= req.port_number;
					use_port_q <= 1'b1;
				end
			endcase
		end
		if (cmd.walk) begin
			idx_s1 <= rd_q[IDX_W-1:0];
		end
		if (cmd.emit) begin
			out_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q        <= '0;
			wr_q        <= '0;
			pv_s1       <= 1'b0;
			total_q     <= '0;
			before_q    <= '0;
			kc_q[0]     <= '0;
			kc_q[1]     <= '0;
			matched_q   <= 1'b0;
			inserted_q  <= 1'b0;
			sub_q       <= 1'b0;
			removed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_q       <= '0;
				wr_q       <= '0;
				pv_s1      <= 1'b0;
				before_q   <= total_q;
				matched_q  <= 1'b0;
				inserted_q <= 1'b0;
				sub_q      <= 1'b0;
				removed_q  <= '0;
			end
			if (cmd.walk) begin
				pv_s1 <= issue;
				if (issue) begin
					rd_q <= rd_q + 1'b1;
				end
			end
			if (eval) begin
				if (is_sweep) begin
					if (drop) begin
						removed_q <= removed_q + 1'b1;
						if (kc_q[rdata.kind] != '0) begin
							kc_q[rdata.kind] <= kc_q[rdata.kind] - 1'b1;
						end
					end else begin
						wr_q <= wr_q + 1'b1;
					end
				end else if (hit_raw) begin
					matched_q <= 1'b1;
				end
			end
			if (cmd.update) begin
				case (cmd_q)
					CMD_ADD: begin
						if (append_ok) begin
							kc_q[kind_q] <= kc_q[kind_q] + 1'b1;
							total_q      <= total_q + 1'b1;
							inserted_q   <= 1'b1;
							sub_q        <= (kc_q[kind_q] == '0);
						end
					end
					CMD_SWEEP: begin
						total_q <= wr_q;
					end
					CMD_CLEAR: begin
						removed_q <= total_q;
						total_q   <= '0;
						kc_q[0]   <= '0;
						kc_q[1]   <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// The table never holds more entries than it has rows.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOTAL_W'(TABLE_DEPTH))
		else $error("entry total above table depth");

	// Outside a walk or an update the two kind counts add up to the total.
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.walk && !cmd.update) |->
		(({1'b0, kc_q[0]} + {1'b0, kc_q[1]}) == (KC_W + 1)'(total_q)))
		else $error("kind counts disagree with entry total");

	// Compaction never writes ahead of the entry being read.
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q <= rd_q)
		else $error("sweep write pointer passed read pointer");

	// A new result is only loaded into a free output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || rsp_ready))
		else $error("result overwritten before it was taken");

endmodule

[sv/aging_peer_table_unit.sv]
// Top level of the aging peer table: configuration registers and the two halves.
//
//  Channel   Direction  Handshake                         Word
//  req       in         req_valid / req_ready             req_t (command and peer)
//  rsp       out        rsp_valid / rsp_ready             rsp_t (flags and counts)
//  apb       in/out     psel, penable, pwrite, pready     timeout_ms, fixed_port
//
// Add, query, refresh and sweep walk the table before the update step: one entry is read
// per cycle through the RAM's registered read, and the walk ends once every entry has been
// evaluated. A match ends the walk early. Clear and unused commands skip the walk and go
// straight to the update step; a word is accepted in the cycle after the previous result is
// loaded. Reset empties the table and loads the register defaults.
// A result stalled in the output register holds the controller only once the next is ready.
module aging_peer_table_unit
	import apt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [31:0]  timeout_q;
	logic [15:0]  fixed_port_q;
	logic         reg_sel;
	logic         cfg_write;
	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	// Registers sit at byte addresses 0 and 4, so bit 2 selects between them.
	assign reg_sel   = paddr[2];
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RESET;
			fixed_port_q <= FIXED_PORT_RESET;
		end else if (cfg_write) begin
			if (reg_sel == REG_TIMEOUT) begin
				timeout_q <= pwdata;
			end else begin
				fixed_port_q <= pwdata[15:0];
			end
		end
	end

	// Reads return the register selected by the address.
	assign prdata = (reg_sel == REG_FIXED_PORT) ? {16'd0, fixed_port_q} : timeout_q;

	// The controller sequences load, walk, update and result hand-off.
	apt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath owns the entry RAM, the counts and the output register.
	apt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.timeout_ms(timeout_q),
		.fixed_port(fixed_port_q),
		.cmd       (cmd),
		.status    (status),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
